// ===== design/mmd_pkg.sv =====
// Shared types and constants of the Mahalanobis minimum-distance classifier.
// Depends on nothing; mmd_front, mmd_back and the top level import it.
`timescale 1ns / 1ps

package mmd_pkg;

   // number of feature ports on the request channel
   localparam int NUM_INPUTS = 7;

   localparam logic [1:0] CMD_LOAD_MEAN = 2'd0;
   localparam logic [1:0] CMD_LOAD_COV  = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY  = 2'd2;

   localparam int CSR_ADDR_W = 4;
   localparam logic CSR_IDX_CLASSES = 1'b0;
   localparam logic CSR_IDX_CEILING = 1'b1;

   localparam logic [46:0] CEILING_RESET = 47'd655360000000;
   localparam logic [4:0]  CLASSES_RESET = 5'd1;

   localparam logic [47:0] DIST_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] DIST_MIN = 48'h8000_0000_0000;

   typedef enum logic [1:0] {
      KIND_MEAN,
      KIND_COV,
      KIND_CLASSIFY
   } kind_type;

   typedef struct packed {
      kind_type                     kind;
      logic [3:0]                   class_sel;
      logic [2:0]                   row_sel;
      logic [2:0]                   col_sel;
      logic [31:0]                  coef_value;
      logic [NUM_INPUTS-1:0][15:0]  feats;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_word_type;

   typedef struct packed {
      logic [4:0]  classes_in_use;
      logic [46:0] distance_ceiling;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_MWAIT,
      ST_COV,
      ST_DRAIN,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

// ===== design/mmd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module mmd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 112
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/mmd_front.sv =====
// Front end: accepts request words, decodes the command, drops command 3 and loads
// outside the stores, and queues the rest in a two-word queue. Uses mmd_pkg.
`timescale 1ns / 1ps

module mmd_front import mmd_pkg::*; #(
   parameter int MAX_CLASSES = 16,
   parameter int FEATURES    = 7
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  item_type       req_item,
   input  logic [1:0]     req_command,
   input  logic           pop,
   output queue_word_type head
);

   item_type   q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       keep, push;
   item_type   word;

   always_comb begin
      word = req_item;
      keep = 1'b0;
      word.kind = KIND_CLASSIFY;
      case (req_command)
         CMD_LOAD_MEAN: begin
            word.kind = KIND_MEAN;
            keep = (int'(req_item.class_sel) < MAX_CLASSES) &&
                   (int'(req_item.row_sel) < FEATURES);
         end
         CMD_LOAD_COV: begin
            word.kind = KIND_COV;
            keep = (int'(req_item.class_sel) < MAX_CLASSES) &&
                   (int'(req_item.row_sel) < FEATURES) &&
                   (int'(req_item.col_sel) < FEATURES);
         end
         CMD_CLASSIFY: keep = 1'b1;
         default:      keep = 1'b0;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall && keep;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

// ===== design/mmd_back.sv =====
// Back end: writes loads into the stores and runs the per-class distance
// sequencer with one multiply-accumulate lane. Uses mmd_pkg.
`timescale 1ns / 1ps

module mmd_back import mmd_pkg::*; #(
   parameter int MAX_CLASSES = 16,
   parameter int FEATURES    = 7
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  queue_word_type head,
   output logic           pop,
   output logic           mean_we,
   output logic [(MAX_CLASSES*FEATURES > 1 ? $clog2(MAX_CLASSES*FEATURES) : 1)-1:0]
                          mean_waddr,
   output logic [(MAX_CLASSES*FEATURES > 1 ? $clog2(MAX_CLASSES*FEATURES) : 1)-1:0]
                          mean_raddr,
   output logic [15:0]    mean_wdata,
   input  logic [15:0]    mean_rdata,
   output logic           cov_we,
   output logic [(MAX_CLASSES*FEATURES*FEATURES > 1 ?
                  $clog2(MAX_CLASSES*FEATURES*FEATURES) : 1)-1:0] cov_waddr,
   output logic [(MAX_CLASSES*FEATURES*FEATURES > 1 ?
                  $clog2(MAX_CLASSES*FEATURES*FEATURES) : 1)-1:0] cov_raddr,
   output logic [31:0]    cov_wdata,
   input  logic [31:0]    cov_rdata,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output logic [4:0]     rsp_class_label,
   output logic [47:0]    rsp_best_distance,
   output logic           rsp_no_match
);

   localparam int MD = MAX_CLASSES * FEATURES;
   localparam int CD = MAX_CLASSES * FEATURES * FEATURES;
   localparam int MA = (MD > 1) ? $clog2(MD) : 1;
   localparam int CA = (CD > 1) ? $clog2(CD) : 1;
   localparam int CW = $clog2(MAX_CLASSES + 1);
   localparam int FI = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int DW = 17;
   localparam int PW = DW + 32;
   localparam int TW = PW + ((FEATURES > 1) ? $clog2(FEATURES) : 0) + 1;
   localparam int T8 = TW - 8;
   localparam int MW = T8 + DW;
   localparam int M8 = MW - 8;
   localparam int SW = M8 + ((FEATURES > 1) ? $clog2(FEATURES) : 0) + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'($signed(DIST_MAX));
   localparam logic signed [SW-1:0] SAT_LO = SW'($signed(DIST_MIN));

   state_type state_ff, state_in;

   logic [CW-1:0] c_ff, n_ff, n_cfg;
   logic [FI-1:0] k_ff, i_ff, j_ff;
   logic          issue_m, issue_c;
   logic          j_last, i_last, k_last;
   logic          rsp_load;

   logic signed [15:0]   x_ff  [FEATURES];
   logic signed [DW-1:0] d_ff  [FEATURES];
   logic signed [DW-1:0] di_ff [FEATURES];
   logic signed [15:0]   x_init [FEATURES];
   logic signed [DW-1:0] d_new;

   logic                 m_v_ff, p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff;
   logic signed [DW-1:0] p1_dj_ff, p1_di_ff, p2_di_ff, p3_di_ff;
   logic                 p1_jfirst_ff, p1_jlast_ff, p2_jfirst_ff, p2_jlast_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [TW-1:0] tacc_ff, acc_sum;
   logic signed [T8-1:0] t_ff;
   logic signed [MW-1:0] term_ff;
   logic signed [M8-1:0] term_hi;
   logic signed [SW-1:0] sum_ff;
   logic signed [47:0]   sat_dist, best_ff;
   logic [4:0]           label_ff;
   logic                 rsp_valid_ff;

   assign n_cfg  = (int'(cfg.classes_in_use) > MAX_CLASSES) ? CW'(MAX_CLASSES)
                                                             : CW'(cfg.classes_in_use);
   assign k_last = (k_ff == FI'(FEATURES - 1));
   assign j_last = (j_ff == FI'(FEATURES - 1));
   assign i_last = (i_ff == FI'(FEATURES - 1));

   assign mean_waddr = MA'(int'(head.item.class_sel) * FEATURES + int'(head.item.row_sel));
   assign mean_wdata = head.item.coef_value[15:0];
   assign cov_waddr  = CA'((int'(head.item.class_sel) * FEATURES + int'(head.item.row_sel))
                           * FEATURES + int'(head.item.col_sel));
   assign cov_wdata  = head.item.coef_value;
   assign mean_raddr = MA'(int'(c_ff) * FEATURES + int'(k_ff));
   assign cov_raddr  = CA'((int'(c_ff) * FEATURES + int'(j_ff)) * FEATURES + int'(i_ff));

   assign d_new   = DW'(x_ff[0]) - DW'($signed(mean_rdata));
   assign acc_sum = (p2_jfirst_ff ? TW'(0) : tacc_ff) + TW'(prod_ff);
   assign term_hi = term_ff[MW-1:8];

   always_comb begin
      for (int f = 0; f < FEATURES; f++) begin
         if (f < NUM_INPUTS) begin
            x_init[f] = head.item.feats[f % NUM_INPUTS];
         end else begin
            x_init[f] = '0;
         end
      end
   end

   always_comb begin
      if (sum_ff > SAT_HI) begin
         sat_dist = DIST_MAX;
      end else if (sum_ff < SAT_LO) begin
         sat_dist = DIST_MIN;
      end else begin
         sat_dist = sum_ff[47:0];
      end
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      mean_we  = 1'b0;
      cov_we   = 1'b0;
      issue_m  = 1'b0;
      issue_c  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.item.kind)
                  KIND_MEAN:     mean_we = 1'b1;
                  KIND_COV:      cov_we  = 1'b1;
                  KIND_CLASSIFY: state_in = (n_cfg == '0) ? ST_DONE : ST_MEAN;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_MEAN: begin
            issue_m = 1'b1;
            if (k_last) begin
               state_in = ST_MWAIT;
            end
         end
         ST_MWAIT: state_in = ST_COV;
         ST_COV: begin
            issue_c = 1'b1;
            if (i_last && j_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!(p1_v_ff || p2_v_ff || p3_v_ff || p4_v_ff)) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: state_in = (CW'(c_ff + 1'b1) == n_ff) ? ST_DONE : ST_MEAN;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         m_v_ff       <= 1'b0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         p3_v_ff      <= 1'b0;
         p4_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         m_v_ff   <= issue_m;
         p1_v_ff  <= issue_c;
         p2_v_ff  <= p1_v_ff;
         p3_v_ff  <= p2_v_ff && p2_jlast_ff;
         p4_v_ff  <= p3_v_ff;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      // start a sample
      if (state_ff == ST_IDLE && head.valid && head.item.kind == KIND_CLASSIFY) begin
         for (int f = 0; f < FEATURES; f++) begin
            x_ff[f] <= x_init[f];
         end
         best_ff  <= {1'b0, cfg.distance_ceiling};
         label_ff <= '0;
         c_ff     <= '0;
         n_ff     <= n_cfg;
         k_ff     <= '0;
         sum_ff   <= '0;
      end

      if (issue_m) begin
         k_ff <= k_last ? '0 : FI'(k_ff + 1'b1);
         i_ff <= '0;
         j_ff <= '0;
      end

      // mean words arrive: shift differences in, rotate the sample
      if (m_v_ff) begin
         for (int f = 0; f < FEATURES - 1; f++) begin
            d_ff[f]  <= d_ff[f+1];
            di_ff[f] <= di_ff[f+1];
         end
         d_ff[FEATURES-1]  <= d_new;
         di_ff[FEATURES-1] <= d_new;
         for (int f = 0; f < FEATURES; f++) begin
            x_ff[f] <= x_ff[(f + 1) % FEATURES];
         end
      end else if (issue_c) begin
         for (int f = 0; f < FEATURES; f++) begin
            d_ff[f] <= d_ff[(f + 1) % FEATURES];
         end
         if (j_last) begin
            for (int f = 0; f < FEATURES; f++) begin
               di_ff[f] <= di_ff[(f + 1) % FEATURES];
            end
         end
      end

      if (issue_c) begin
         p1_dj_ff     <= d_ff[0];
         p1_di_ff     <= di_ff[0];
         p1_jfirst_ff <= (j_ff == '0);
         p1_jlast_ff  <= j_last;
         j_ff         <= j_last ? '0 : FI'(j_ff + 1'b1);
         if (j_last) begin
            i_ff <= i_last ? '0 : FI'(i_ff + 1'b1);
         end
      end

      if (p1_v_ff) begin
         prod_ff      <= p1_dj_ff * $signed(cov_rdata);
         p2_di_ff     <= p1_di_ff;
         p2_jfirst_ff <= p1_jfirst_ff;
         p2_jlast_ff  <= p1_jlast_ff;
      end

      if (p2_v_ff) begin
         tacc_ff <= acc_sum;
         if (p2_jlast_ff) begin
            t_ff     <= acc_sum[TW-1:8];
            p3_di_ff <= p2_di_ff;
         end
      end

      if (p3_v_ff) begin
         term_ff <= t_ff * p3_di_ff;
      end

      if (p4_v_ff) begin
         sum_ff <= sum_ff + SW'(term_hi);
      end

      if (state_ff == ST_CMP) begin
         if (sat_dist < best_ff) begin
            best_ff  <= sat_dist;
            label_ff <= 5'(c_ff + 1'b1);
         end
         c_ff   <= CW'(c_ff + 1'b1);
         sum_ff <= '0;
         k_ff   <= '0;
      end

      if (rsp_load) begin
         rsp_class_label   <= label_ff;
         rsp_best_distance <= best_ff;
         rsp_no_match      <= (label_ff == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/mahalanobis_min_distance_classify.sv =====
// Mahalanobis minimum-distance classifier: a load words fill the class-mean and
// inverse-covariance stores; a classify word carries seven Q8.8 features and
// returns the nearest class. Built from mmd_front, mmd_back and mmd_ram; uses mmd_pkg.
`timescale 1ns / 1ps

// A load word (mean or coefficient) gives no response; loads that address a class,
// row or column beyond the stores, and command 3, are dropped. A classify word
// walks classes 0 .. classes_in_use-1 (at most MAX_CLASSES) through one
// multiply-accumulate lane fed from the coefficient RAM's single read port:
// per class the sequencer reads the means, waits for the last mean word,
// streams the coefficients, drains the two-multiplier pipeline and compares.
// Distances saturate to signed 48 bits; a class wins only when strictly below
// the running best, which starts at distance_ceiling, so the lower class wins
// a tie. With no match the response carries label 0, no_match set and the
// ceiling as best_distance. A two-word queue separates request intake from the
// sequencer and the response sits in its own register, so request words are
// still taken, until the queue is full, while a response waits.
// Registers: classes_in_use at byte 0x0 (reset 1), distance_ceiling at 0x8
// (reset 1e7 in Q31.16). Write them only while the block is idle.

module mahalanobis_min_distance_classify import mmd_pkg::*; #(
   parameter int MAX_CLASSES = 16,
   parameter int FEATURES    = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic [3:0]            req_class_sel,
   input  logic [2:0]            req_row_sel,
   input  logic [2:0]            req_col_sel,
   input  logic signed [31:0]    req_coef_value,
   input  logic signed [15:0]    req_feat_red,
   input  logic signed [15:0]    req_feat_green,
   input  logic signed [15:0]    req_feat_blue,
   input  logic signed [15:0]    req_feat_coarse,
   input  logic signed [15:0]    req_feat_direction,
   input  logic signed [15:0]    req_feat_contrast,
   input  logic signed [15:0]    req_feat_rough,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [4:0]            rsp_class_label,
   output logic signed [47:0]    rsp_best_distance,
   output logic                  rsp_no_match,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0]           csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int MD = MAX_CLASSES * FEATURES;
   localparam int CD = MAX_CLASSES * FEATURES * FEATURES;
   localparam int MA = (MD > 1) ? $clog2(MD) : 1;
   localparam int CA = (CD > 1) ? $clog2(CD) : 1;

   cfg_type        cfg_ff;
   item_type       req_item;
   queue_word_type head;
   logic           pop;

   logic           mean_we, cov_we;
   logic [MA-1:0]  mean_waddr, mean_raddr;
   logic [CA-1:0]  cov_waddr, cov_raddr;
   logic [15:0]    mean_wdata, mean_rdata;
   logic [31:0]    cov_wdata, cov_rdata;
   logic           csr_write;

   // register port: every write lands at the access edge, no wait states
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.classes_in_use   <= CLASSES_RESET;
         cfg_ff.distance_ceiling <= CEILING_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3])
            CSR_IDX_CLASSES: cfg_ff.classes_in_use   <= csr_pwdata[4:0];
            CSR_IDX_CEILING: cfg_ff.distance_ceiling <= csr_pwdata[46:0];
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3])
         CSR_IDX_CLASSES: csr_prdata = {59'd0, cfg_ff.classes_in_use};
         CSR_IDX_CEILING: csr_prdata = {17'd0, cfg_ff.distance_ceiling};
         default:         csr_prdata = '0;
      endcase
   end

   // pack the request word; the front end fills in the decoded kind
   always_comb begin
      req_item            = '0;
      req_item.class_sel  = req_class_sel;
      req_item.row_sel    = req_row_sel;
      req_item.col_sel    = req_col_sel;
      req_item.coef_value = req_coef_value;
      req_item.feats[0]   = req_feat_red;
      req_item.feats[1]   = req_feat_green;
      req_item.feats[2]   = req_feat_blue;
      req_item.feats[3]   = req_feat_coarse;
      req_item.feats[4]   = req_feat_direction;
      req_item.feats[5]   = req_feat_contrast;
      req_item.feats[6]   = req_feat_rough;
   end

   mmd_front #(
      .MAX_CLASSES (MAX_CLASSES),
      .FEATURES    (FEATURES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .req_command (req_command),
      .pop         (pop),
      .head        (head)
   );

   // class means, Q8.8, at class*FEATURES+row
   mmd_ram #(
      .WIDTH (16),
      .DEPTH (MD)
   ) u_mean_ram (
      .clock   (clock),
      .wr_en   (mean_we),
      .wr_addr (mean_waddr),
      .wr_data (mean_wdata),
      .rd_addr (mean_raddr),
      .rd_data (mean_rdata)
   );

   // inverse covariance, Q16.16, at (class*FEATURES+row)*FEATURES+col
   mmd_ram #(
      .WIDTH (32),
      .DEPTH (CD)
   ) u_cov_ram (
      .clock   (clock),
      .wr_en   (cov_we),
      .wr_addr (cov_waddr),
      .wr_data (cov_wdata),
      .rd_addr (cov_raddr),
      .rd_data (cov_rdata)
   );

   mmd_back #(
      .MAX_CLASSES (MAX_CLASSES),
      .FEATURES    (FEATURES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head              (head),
      .pop               (pop),
      .mean_we           (mean_we),
      .mean_waddr        (mean_waddr),
      .mean_raddr        (mean_raddr),
      .mean_wdata        (mean_wdata),
      .mean_rdata        (mean_rdata),
      .cov_we            (cov_we),
      .cov_waddr         (cov_waddr),
      .cov_raddr         (cov_raddr),
      .cov_wdata         (cov_wdata),
      .cov_rdata         (cov_rdata),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_class_label   (rsp_class_label),
      .rsp_best_distance (rsp_best_distance),
      .rsp_no_match      (rsp_no_match)
   );

endmodule
